[sv/rhcm_pkg.sv]
// Package for the RGB to HSV color match pipeline: widths, stage counts,
// register indexes and the divider stage record. No dependencies.
package rhcm_pkg;

   localparam int ChanW      = 8;                   // one color channel
   localparam int SatNumW    = 2 * ChanW;           // delta * 255
   localparam int HueQW      = 6;                   // hue sector offset is at most 60
   localparam int HueNumW    = ChanW + HueQW;       // 60 * |diff|
   localparam int HueW       = 9;                   // hue in degrees, 0..359
   localparam int HueScW     = 10;                  // (hue * 17) >> 3, at most 762
   localparam int DivSteps   = ChanW;               // one quotient bit per stage
   localparam int RecipMul   = 683;                 // 2^11 / 3, rounded up
   localparam int RecipShift = 11;
   localparam int CsrIdxW    = 3;
   localparam int ReqDataW   = 3 * ChanW;
   localparam int RspDataW   = 32;                  // 25 bits of fields, padded to bytes

   // front stage, divider registers, hue assemble, hue scale, match/output
   localparam int NumStages  = 1 + (DivSteps + 1) + 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_HUE_LOW  = 3'd0,
      CSR_HUE_HIGH = 3'd1,
      CSR_SAT_MIN  = 3'd2,
      CSR_SAT_MAX  = 3'd3,
      CSR_VAL_MIN  = 3'd4,
      CSR_VAL_MAX  = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   // one stage of the two restoring dividers running side by side
   typedef struct packed {
      logic [ChanW-1:0] val;        // max channel, also the saturation divisor
      logic [ChanW-1:0] delta;      // max - min, the hue divisor
      logic             grey;       // delta is zero
      sector_type       sector;
      logic             neg;        // hue difference was negative
      logic [ChanW-1:0] sat_rem;
      logic [ChanW-1:0] sat_low;    // numerator bits not yet shifted in
      logic [ChanW-1:0] sat_q;
      logic [ChanW-1:0] hue_rem;
      logic [HueQW-1:0] hue_low;
      logic [HueQW-1:0] hue_q;
   } div_stage_type;

endpackage

[sv/rgb_to_hsv_color_match_top.sv]
// Top level of the RGB to HSV color match pipeline.
// Depends on rhcm_pkg for widths, register indexes and the divider stage record.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | req_tdata: red, green, blue
//   rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: hue, sat, val, is_match
//   csr     | in  | csr_wr_en             | csr_index, csr_wdata
//
// One pixel per clock unless rsp stalls. Stages: front, 8-step restoring
// saturation divider (one quotient bit per stage) beside the hue divider,
// hue assembly, hue scaling and match. Each stage has its own valid bit
// and advances when the next stage is empty or moving, so bubbles close up
// under a stall on rsp. Reset clears valid bits and loads the bounds.
module rgb_to_hsv_color_match_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] pix_red, [15:8] pix_green, [23:16] pix_blue
   input  logic [rhcm_pkg::ReqDataW-1:0]     req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] hue_out, [15:8] sat_out, [23:16] val_out, [24] is_match, rest zero
   output logic [rhcm_pkg::RspDataW-1:0]     rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [rhcm_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [rhcm_pkg::ChanW-1:0]        csr_wdata
);
   import rhcm_pkg::*;

   localparam int StDiv0  = 1;
   localparam int StHueA  = StDiv0 + DivSteps + 1;
   localparam int StHueB  = StHueA + 1;
   localparam int StMatch = StHueB + 1;

   // bound registers
   logic [ChanW-1:0] hue_low_ff, hue_high_ff, sat_min_ff, sat_max_ff;
   logic [ChanW-1:0] val_min_ff, val_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= ChanW'(30);
         hue_high_ff <= ChanW'(220);
         sat_min_ff  <= ChanW'(0);
         sat_max_ff  <= ChanW'(255);
         val_min_ff  <= ChanW'(150);
         val_max_ff  <= ChanW'(255);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HUE_LOW:  hue_low_ff  <= csr_wdata;
            CSR_HUE_HIGH: hue_high_ff <= csr_wdata;
            CSR_SAT_MIN:  sat_min_ff  <= csr_wdata;
            CSR_SAT_MAX:  sat_max_ff  <= csr_wdata;
            CSR_VAL_MIN:  val_min_ff  <= csr_wdata;
            CSR_VAL_MAX:  val_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage flow control
   logic [NumStages-1:0] vld_ff, vld_in, en;

   always_comb begin
      en[NumStages-1] = !vld_ff[NumStages-1] || rsp_tready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in = {vld_ff[NumStages-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NumStages; i++) begin
            if (en[i]) vld_ff[i] <= vld_in[i];
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[NumStages-1];

   // front stage: max, min, sector and signed channel difference
   logic [ChanW-1:0]   red, green, blue;
   logic [ChanW-1:0]   mx, mn;
   logic signed [ChanW:0] diff;
   logic [ChanW:0]     diff_abs;
   sector_type         sector_in;

   logic [ChanW-1:0]   f_val_ff, f_delta_ff, f_absdiff_ff;
   logic               f_neg_ff;
   sector_type         f_sector_ff;

   always_comb begin
      red   = req_tdata[ChanW-1:0];
      green = req_tdata[2*ChanW-1:ChanW];
      blue  = req_tdata[3*ChanW-1:2*ChanW];
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      if (red == mx) begin
         sector_in = SECT_RED;
         diff = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green == mx) begin
         sector_in = SECT_GREEN;
         diff = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         sector_in = SECT_BLUE;
         diff = $signed({1'b0, red}) - $signed({1'b0, green});
      end
      diff_abs = diff[ChanW] ? (~diff + 1'b1) : diff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         f_val_ff     <= mx;
         f_delta_ff   <= mx - mn;
         f_absdiff_ff <= diff_abs[ChanW-1:0];
         f_neg_ff     <= diff[ChanW];
         f_sector_ff  <= sector_in;
      end
   end

   // divider stages: div_ff[0] holds the numerators, div_ff[k] has k saturation quotient bits
   div_stage_type          div_ff [DivSteps+1];
   div_stage_type          div_in [DivSteps+1];
   logic [SatNumW-1:0]     sat_num;
   logic [HueNumW-1:0]     hue_num;
   logic [ChanW:0]         sat_rem9 [DivSteps];
   logic [ChanW:0]         hue_rem9 [DivSteps];

   always_comb begin
      sat_num = {f_delta_ff, {ChanW{1'b0}}} - SatNumW'(f_delta_ff);
      hue_num = {f_absdiff_ff, 6'b0} - HueNumW'({f_absdiff_ff, 2'b0});
      div_in[0].val     = f_val_ff;
      div_in[0].delta   = f_delta_ff;
      div_in[0].grey    = (f_delta_ff == '0);
      div_in[0].sector  = f_sector_ff;
      div_in[0].neg     = f_neg_ff;
      div_in[0].sat_rem = sat_num[SatNumW-1:ChanW];
      div_in[0].sat_low = sat_num[ChanW-1:0];
      div_in[0].sat_q   = '0;
      div_in[0].hue_rem = hue_num[HueNumW-1:HueQW];
      div_in[0].hue_low = hue_num[HueQW-1:0];
      div_in[0].hue_q   = '0;
      for (int k = 0; k < DivSteps; k++) begin
         div_in[k+1] = div_ff[k];
         sat_rem9[k] = {div_ff[k].sat_rem, div_ff[k].sat_low[ChanW-1]};
         div_in[k+1].sat_low = {div_ff[k].sat_low[ChanW-2:0], 1'b0};
         if (sat_rem9[k] >= {1'b0, div_ff[k].val}) begin
            div_in[k+1].sat_rem = ChanW'(sat_rem9[k] - {1'b0, div_ff[k].val});
            div_in[k+1].sat_q   = {div_ff[k].sat_q[ChanW-2:0], 1'b1};
         end else begin
            div_in[k+1].sat_rem = sat_rem9[k][ChanW-1:0];
            div_in[k+1].sat_q   = {div_ff[k].sat_q[ChanW-2:0], 1'b0};
         end
         // hue quotient is narrower: its steps run in the first HueQW stages
         hue_rem9[k] = {div_ff[k].hue_rem, div_ff[k].hue_low[HueQW-1]};
         if (k < HueQW) begin
            div_in[k+1].hue_low = {div_ff[k].hue_low[HueQW-2:0], 1'b0};
            if (hue_rem9[k] >= {1'b0, div_ff[k].delta}) begin
               div_in[k+1].hue_rem = ChanW'(hue_rem9[k] - {1'b0, div_ff[k].delta});
               div_in[k+1].hue_q   = {div_ff[k].hue_q[HueQW-2:0], 1'b1};
            end else begin
               div_in[k+1].hue_rem = hue_rem9[k][ChanW-1:0];
               div_in[k+1].hue_q   = {div_ff[k].hue_q[HueQW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DivSteps; k++) begin
         if (en[StDiv0+k]) div_ff[k] <= div_in[k];
      end
   end

   // hue assembly: sector offset, sign, wrap, then * 17 >> 3 (255/360 = 17/24)
   div_stage_type      dq;
   logic [HueW-1:0]    hue_deg;
   logic [HueW-1:0]    q9;
   logic [HueScW+2:0]  hue_x17;
   logic [HueScW-1:0]  ha_hx_ff;
   logic [ChanW-1:0]   ha_sat_ff, ha_val_ff;

   always_comb begin
      dq = div_ff[DivSteps];
      q9 = HueW'(dq.hue_q);
      case (dq.sector)
         SECT_RED:   hue_deg = (dq.neg && q9 != '0) ? HueW'(360) - q9 : q9;
         SECT_GREEN: hue_deg = dq.neg ? HueW'(120) - q9 : HueW'(120) + q9;
         SECT_BLUE:  hue_deg = dq.neg ? HueW'(240) - q9 : HueW'(240) + q9;
         default:    hue_deg = '0;
      endcase
      if (dq.grey) hue_deg = '0;
      hue_x17 = {hue_deg, 4'b0} + (HueScW+3)'(hue_deg);
   end

   always_ff @(posedge clock) begin
      if (en[StHueA]) begin
         ha_hx_ff  <= hue_x17[HueScW+2:3];
         ha_sat_ff <= dq.grey ? '0 : dq.sat_q;
         ha_val_ff <= dq.val;
      end
   end

   // hue scaling: divide by 3 through the reciprocal, exact for inputs up to 762
   logic [HueScW+RecipShift-1:0] hue_prod;
   logic [ChanW-1:0]  hb_hue_ff, hb_sat_ff, hb_val_ff;

   assign hue_prod = (HueScW+RecipShift)'(ha_hx_ff) * (HueScW+RecipShift)'(RecipMul);

   always_ff @(posedge clock) begin
      if (en[StHueB]) begin
         hb_hue_ff <= hue_prod[RecipShift+ChanW-1:RecipShift];
         hb_sat_ff <= ha_sat_ff;
         hb_val_ff <= ha_val_ff;
      end
   end

   // match against the bounds, output register
   logic               hit;
   logic [ChanW-1:0]   o_hue_ff, o_sat_ff, o_val_ff;
   logic               o_match_ff;

   always_comb begin
      hit = (hb_hue_ff <= hue_low_ff || hb_hue_ff >= hue_high_ff)
         && (hb_sat_ff >= sat_min_ff && hb_sat_ff <= sat_max_ff)
         && (hb_val_ff >= val_min_ff && hb_val_ff <= val_max_ff);
   end

   always_ff @(posedge clock) begin
      if (en[StMatch]) begin
         o_hue_ff   <= hb_hue_ff;
         o_sat_ff   <= hb_sat_ff;
         o_val_ff   <= hb_val_ff;
         o_match_ff <= hit;
      end
   end

   assign rsp_tdata = {{(RspDataW-3*ChanW-1){1'b0}}, o_match_ff, o_val_ff, o_sat_ff, o_hue_ff};

endmodule
